// ===== rtl/manchester_edge_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// manchester_edge_receiver_assert.svh
// assertion macros used by the receiver checker
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_EDGE_RECEIVER_ASSERT_SVH
`define MANCHESTER_EDGE_RECEIVER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MER_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("manchester_edge_receiver: implication check failed");

// implication whose consequent is checked in the next cycle
`define MER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("manchester_edge_receiver: next-cycle check failed");

`endif

// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// shared widths and constants of the manchester edge receiver
// ----------------------------------------------------------------------------
package mer_pkg;

  // half-bit timer width
  localparam int unsigned TimerWidth = 16;
  // received word width and bit counter width
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = $clog2(ByteWidth);
  // timeout after reset
  localparam logic [TimerWidth-1:0] TimeoutReset = TimerWidth'(1000);

  typedef logic [TimerWidth-1:0] timer_t;
  typedef logic [ByteWidth-1:0]  byte_t;
  typedef logic [CountWidth-1:0] bit_cnt_t;

endpackage

// ===== rtl/mer_if.sv =====
// ----------------------------------------------------------------------------
// mer_if
// handshake channels of the manchester edge receiver
// ----------------------------------------------------------------------------

// line sample channel
interface mer_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic line_idle;
  modport source (output valid, output line_level, output line_idle, input ready);
  modport sink (input valid, input line_level, input line_idle, output ready);
endinterface

// received word channel
interface mer_out_if;
  logic           valid;
  logic           ready;
  mer_pkg::byte_t data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// timeout register write channel
interface mer_cfg_if;
  logic            valid;
  logic            ready;
  mer_pkg::timer_t half_bit_timeout;
  modport source (output valid, output half_bit_timeout, input ready);
  modport sink (input valid, input half_bit_timeout, output ready);
endinterface

// ===== rtl/manchester_edge_receiver.sv =====
// ----------------------------------------------------------------------------
// manchester_edge_receiver
// edge driven manchester decoder with a half-bit re-arm timer
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | line_level, line_idle
//  out_o   | out | valid / ready | data_byte
//  cfg_i   | in  | valid / ready | half_bit_timeout
//
//  one line sample is taken every cycle while in_i.ready is high; a word is
//  registered into the first free entry of a two-entry output register pair.
//  in_i.ready drops only while both output entries hold words, so a sample
//  stalls only behind a stalled output; cfg_i.ready is always high.
//  reset clears the decoder to armed, timer running, timeout 1000.
// ----------------------------------------------------------------------------
module manchester_edge_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  mer_in_if.sink      in_i,
  mer_out_if.source   out_o,
  mer_cfg_if.sink     cfg_i
);

  // decoder state
  mer_pkg::timer_t   timeout_q;
  logic              prev_level_q;
  logic              sample_next_q, sample_next_d;
  mer_pkg::bit_cnt_t bit_count_q, bit_count_d;
  mer_pkg::byte_t    shift_byte_q, shift_byte_d;
  mer_pkg::timer_t   timer_q, timer_d;
  logic              running_q, running_d;

  // output entries
  logic              main_v_q, main_v_d;
  mer_pkg::byte_t    main_q, main_d;
  logic              skid_v_q, skid_v_d;
  mer_pkg::byte_t    skid_q, skid_d;

  logic              accept;
  logic              edge_seen;
  logic              restarted;
  logic              emit;
  logic              pop;
  mer_pkg::timer_t   timer_inc;
  logic              mv;

  assign in_i.ready  = !skid_v_q;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign edge_seen   = in_i.line_level != prev_level_q;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= mer_pkg::TimeoutReset;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.half_bit_timeout;
    end
  end

  // idle, edge and timer handling for one sample
  always_comb begin
    sample_next_d = sample_next_q;
    bit_count_d   = bit_count_q;
    shift_byte_d  = shift_byte_q;
    timer_d       = timer_q;
    running_d     = running_q;
    restarted     = 1'b0;
    emit          = 1'b0;
    timer_inc     = timer_q + mer_pkg::timer_t'(1);
    if (in_i.line_idle) begin
      bit_count_d   = '0;
      shift_byte_d  = '0;
      sample_next_d = 1'b1;
    end else if (edge_seen) begin
      if (sample_next_q) begin
        timer_d       = '0;
        running_d     = 1'b1;
        restarted     = 1'b1;
        sample_next_d = 1'b0;
        shift_byte_d[~bit_count_q] = in_i.line_level;
        bit_count_d   = bit_count_q + mer_pkg::bit_cnt_t'(1);
        emit          = &bit_count_q;
      end else begin
        sample_next_d = 1'b1;
        running_d     = 1'b0;
      end
    end
    if (running_d && !restarted) begin
      timer_d = timer_inc;
      if (timer_inc == timeout_q) begin
        sample_next_d = 1'b1;
        running_d     = 1'b0;
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= 1'b0;
      sample_next_q <= 1'b1;
      bit_count_q   <= '0;
      shift_byte_q  <= '0;
      timer_q       <= '0;
      running_q     <= 1'b1;
    end else if (accept) begin
      prev_level_q  <= in_i.line_level;
      sample_next_q <= sample_next_d;
      bit_count_q   <= bit_count_d;
      shift_byte_q  <= shift_byte_d;
      timer_q       <= timer_d;
      running_q     <= running_d;
    end
  end

  // output entry pair: pop first, then push into the first free entry
  assign pop = main_v_q && out_o.ready;
  always_comb begin
    mv       = pop ? skid_v_q : main_v_q;
    main_d   = pop ? skid_q : main_q;
    skid_v_d = pop ? 1'b0 : skid_v_q;
    skid_d   = skid_q;
    main_v_d = mv;
    if (accept && emit) begin
      if (!mv) begin
        main_d   = shift_byte_d;
        main_v_d = 1'b1;
      end else begin
        skid_d   = shift_byte_d;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_o.valid     = main_v_q;
  assign out_o.data_byte = main_q;

endmodule

// ===== rtl/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// port level checks of the manchester edge receiver
// ----------------------------------------------------------------------------
`include "manchester_edge_receiver_assert.svh"

module mer_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           line_idle_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input mer_pkg::byte_t data_byte_i,
  input logic           cfg_ready_i
);

  // a word waiting at the output holds until taken
  `MER_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(data_byte_i))
  // samples are only held back when words are waiting
  `MER_ASSERT_IMP(a_in_ready, !out_valid_i, in_ready_i)
  // a word appears only after an accepted sample
  `MER_ASSERT_IMP(a_out_cause, $rose(out_valid_i), $past(in_valid_i && in_ready_i))
  // an idle sample never completes a word
  `MER_ASSERT_NEXT(a_idle_quiet, in_valid_i && in_ready_i && line_idle_i && !out_valid_i,
                   !out_valid_i)
  // the timeout register takes every write
  `MER_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready_i)

endmodule

bind manchester_edge_receiver mer_checker u_mer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .line_idle_i (in_i.line_idle),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .data_byte_i (out_o.data_byte),
  .cfg_ready_i (cfg_i.ready)
);

// ===== verif/manchester_edge_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// manchester_edge_receiver_tb
// self-checking bench for the edge driven manchester receiver
// ----------------------------------------------------------------------------
//  line samples go in through a bursty sender. A scoreboard keeps its own copy
//  of the decoder state, works out the words each sample should complete, and
//  checks every word taken from the output against the oldest prediction.
//  A short directed run is followed by well-formed manchester frames, line
//  noise and broken frames under several half-bit timeouts, extremes included.
//  The output side stalls on patterns of its own.
// ----------------------------------------------------------------------------
module manchester_edge_receiver_tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned PhaseSamples  = 135;
  localparam int unsigned NumSettings   = 10;

  // decoder state shadow and store of words still to arrive
  class word_tracker;
    mer_pkg::timer_t   half_bit_timeout;
    mer_pkg::timer_t   timeout_count;
    logic              prev_level;
    logic              sample_next;
    logic              timer_running;
    mer_pkg::bit_cnt_t bit_count;
    mer_pkg::byte_t    shift_byte;
    mer_pkg::byte_t    expected_words[$];
    int unsigned       mismatches;
    int unsigned       words_seen;
    int unsigned       samples_seen;

    function new();
      half_bit_timeout = mer_pkg::TimeoutReset;
      timeout_count    = '0;
      prev_level       = 1'b0;
      sample_next      = 1'b1;
      timer_running    = 1'b1;
      bit_count        = '0;
      shift_byte       = '0;
      mismatches       = 0;
      words_seen       = 0;
      samples_seen     = 0;
    endfunction

    function void set_timeout(mer_pkg::timer_t value);
      half_bit_timeout = value;
    endfunction

    // one accepted line sample
    function void note_sample(logic level, logic idle);
      logic line_edge;
      logic restarted;
      samples_seen++;
      line_edge  = (level != prev_level);
      restarted  = 1'b0;
      prev_level = level;
      // idle wins over any edge in the same tick
      if (idle) begin
        bit_count   = '0;
        shift_byte  = '0;
        sample_next = 1'b1;
      end else if (line_edge) begin
        if (sample_next) begin
          // msb first: bit position is 7 - bit_count
          shift_byte[~bit_count] = level;
          timeout_count = '0;
          timer_running = 1'b1;
          restarted     = 1'b1;
          sample_next   = 1'b0;
          if (bit_count == mer_pkg::bit_cnt_t'(mer_pkg::ByteWidth-1)) begin
            expected_words.push_back(shift_byte);
          end
          bit_count = bit_count + mer_pkg::bit_cnt_t'(1);
        end else begin
          sample_next   = 1'b1;
          timer_running = 1'b0;
        end
      end
      // half-bit timer advances after the edge handling
      if (timer_running && !restarted) begin
        timeout_count = timeout_count + mer_pkg::timer_t'(1);
        if (timeout_count == half_bit_timeout) begin
          sample_next   = 1'b1;
          timer_running = 1'b0;
        end
      end
    endfunction

    // one word taken from the output
    function void check_word(mer_pkg::byte_t actual);
      mer_pkg::byte_t want;
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d: none expected, got %02h", words_seen, actual);
        end
        return;
      end
      want = expected_words.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d: data_byte expected %02h, got %02h", words_seen, want, actual);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // words never delivered count against the run
    function void close();
      if (expected_words.size() != 0) begin
        $display("%0d expected words never arrived", expected_words.size());
        mismatches += expected_words.size();
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  word_tracker tracker = new();

  mer_in_if  in_ch ();
  mer_out_if out_ch ();
  mer_cfg_if cfg_ch ();

  manchester_edge_receiver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // sender state
  bit              sending;
  int unsigned     burst_left;
  int unsigned     settings_used;
  mer_pkg::timer_t cur_timeout;
  int unsigned     stall_cycles;

  // monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        tracker.note_sample(in_ch.line_level, in_ch.line_idle);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        tracker.check_word(out_ch.data_byte);
      end
      if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
        tracker.set_timeout(cfg_ch.half_bit_timeout);
      end
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles", stall_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // output stall patterns, changed window by window
  initial begin
    int unsigned    window;
    int unsigned    step;
    mer_pkg::byte_t mask;
    window = 0;
    step   = 0;
    mask   = 8'hFF;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (window == 0) begin
        window = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: mask = 8'hFF;
          1: mask = mer_pkg::byte_t'($urandom);
          2: mask = 8'h01;
          default: begin
            mask   = 8'h00;
            window = $urandom_range(4, 40);
          end
        endcase
      end
      window--;
      step++;
      out_ch.ready <= mask[3'(step % 8)];
    end
  end

  // one line sample, with bursts and gaps on the sender side
  task automatic send_sample(logic level, logic idle);
    if (!sending) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      sending    = 1'b1;
    end
    in_ch.valid      <= 1'b1;
    in_ch.line_level <= level;
    in_ch.line_idle  <= idle;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // hold off until every predicted word is out and the pipe has settled;
  // the clock is awaited first so the last accepted sample has been noted
  task automatic wait_for_words();
    if (sending) begin
      in_ch.valid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(mer_pkg::timer_t value);
    wait_for_words();
    cfg_ch.valid            <= 1'b1;
    cfg_ch.half_bit_timeout <= value;
    @(posedge clk_i);
    while (cfg_ch.ready !== 1'b1) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    cur_timeout = value;
    settings_used++;
  endtask

  // manchester frame: idle lead-in, then per bit ~b then b for half samples each;
  // a broken frame stops early, sometimes with idle mid-byte
  task automatic send_frame(mer_pkg::byte_t word, int unsigned half, bit broken);
    int unsigned cut;
    logic        lvl;
    cut = broken ? $urandom_range(0, 15) : 16;
    repeat ($urandom_range(1, 3)) send_sample(~word[mer_pkg::ByteWidth-1], 1'b1);
    for (int h = 0; h < 16; h++) begin
      if (h == cut) begin
        if ($urandom_range(0, 1)) send_sample(1'($urandom_range(0, 1)), 1'b1);
        return;
      end
      lvl = (h % 2 == 0) ? ~word[3'(mer_pkg::ByteWidth-1-h/2)] :
                           word[3'(mer_pkg::ByteWidth-1-h/2)];
      repeat (half) send_sample(lvl, 1'b0);
    end
  endtask

  // random line activity with occasional idle
  task automatic send_noise(int unsigned count);
    repeat (count) send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
  endtask

  // random traffic under the current timeout
  task automatic run_phase(int unsigned quota);
    int unsigned    start;
    int unsigned    half;
    int unsigned    pick;
    mer_pkg::byte_t word;
    start = tracker.samples_seen;
    while (tracker.samples_seen - start < quota) begin
      // a half bit sits between (timeout+2)/2 and the timeout for timeouts up to 32, else 1 to 4 samples
      if (cur_timeout <= 32) begin
        half = $urandom_range((int'(cur_timeout) + 2) / 2, int'(cur_timeout));
      end else begin
        half = $urandom_range(1, 4);
      end
      case ($urandom_range(0, 9))
        0: word = 8'h00;
        1: word = 8'hFF;
        default: word = mer_pkg::byte_t'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(word, half, 1'b0);
      end else if (pick < 85) begin
        send_noise($urandom_range(4, 40));
      end else if (pick < 97) begin
        send_frame(word, half, 1'b1);
      end else begin
        wait_for_words();
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    int unsigned timeouts [NumSettings];
    timeouts = '{1, 2, 3, 5, 8, 13, 20, 65535, 0, 0};
    timeouts[8] = $urandom_range(1, 24);
    timeouts[9] = $urandom_range(4, 32);
    sending       = 1'b0;
    burst_left    = 0;
    settings_used = 1;
    cur_timeout   = mer_pkg::TimeoutReset;
    stall_cycles  = 0;
    rst_ni                  <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.line_level        <= 1'b0;
    in_ch.line_idle         <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.half_bit_timeout <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: quiet line, then two idle samples that each hide an edge
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    // toggling line: every other edge samples a one, giving ff
    for (int i = 0; i < 16; i++) send_sample(i % 2 == 0, 1'b0);
    // idle moves the level up, then zeros are sampled and idle drops the part byte
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);

    run_phase(PhaseSamples);
    foreach (timeouts[i]) begin
      write_timeout(mer_pkg::timer_t'(timeouts[i]));
      run_phase(PhaseSamples);
    end

    wait_for_words();
    tracker.close();
    $display("covered %0d line samples and %0d words over %0d timeout settings",
             tracker.samples_seen, tracker.words_seen, settings_used);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
